// ===== src/spia_pkg.sv =====
// spia_pkg: opcodes, lane width codes and shared types for the packed integer alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spia_pkg;

  localparam int unsigned DataW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned MulLanes = 8;

  typedef enum logic [3:0] {
    OP_CMPEQ  = 4'd0,
    OP_CMPGT  = 4'd1,
    OP_SMIN   = 4'd2,
    OP_SMAX   = 4'd3,
    OP_UMIN   = 4'd4,
    OP_UMAX   = 4'd5,
    OP_AVG    = 4'd6,
    OP_SMULHI = 4'd7,
    OP_UMULHI = 4'd8,
    OP_SLL    = 4'd9,
    OP_SRL    = 4'd10,
    OP_SRA    = 4'd11,
    OP_PACKSS = 4'd12,
    OP_PACKUS = 4'd13
  } opcode_t;

  localparam logic [1:0] ES_8  = 2'd0;
  localparam logic [1:0] ES_16 = 2'd1;
  localparam logic [1:0] ES_32 = 2'd2;
  localparam logic [1:0] ES_64 = 2'd3;

  typedef struct packed {
    logic [3:0]       opcode;
    logic [1:0]       lane_code;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } op_item_t;

  function automatic logic combo_ok(input logic [3:0] op, input logic [1:0] es);
    logic ok;
    ok = 1'b0;
    case (op)
      OP_CMPEQ, OP_CMPGT: ok = 1'b1;
      OP_SMIN, OP_SMAX, OP_UMIN, OP_UMAX: ok = (es != ES_64);
      OP_AVG: ok = (es == ES_8) || (es == ES_16);
      OP_SMULHI, OP_UMULHI: ok = (es == ES_16);
      OP_SLL, OP_SRL: ok = (es != ES_8);
      OP_SRA, OP_PACKSS, OP_PACKUS: ok = (es == ES_16) || (es == ES_32);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== src/spia_if.sv =====
// spia_in_if / spia_out_if: valid-ready channels of the packed integer alu
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface spia_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [1:0]  lane_code;
  logic [63:0] a_lo;
  logic [63:0] a_hi;
  logic [63:0] b_lo;
  logic [63:0] b_hi;
  modport source (output valid, opcode, lane_code, a_lo, a_hi, b_lo, b_hi, input ready);
  modport sink (input valid, opcode, lane_code, a_lo, a_hi, b_lo, b_hi, output ready);
endinterface

interface spia_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] r_lo;
  logic [63:0] r_hi;
  logic        bad_combo;
  modport source (output valid, r_lo, r_hi, bad_combo, input ready);
  modport sink (input valid, r_lo, r_hi, bad_combo, output ready);
endinterface
`default_nettype wire

// ===== src/simd_packed_integer_alu.sv =====
// simd_packed_integer_alu: three-stage packed integer alu on 128-bit operands
// depends on spia_pkg and the channel interfaces in spia_if.sv
// throughput: one transaction per cycle; the whole pipeline advances together
//   and stalls only when the output register is full and not taken
// stage 1 decodes the pair, forms the 16-bit products and decodes the shift count;
// stage 2 does lane compares, selection, shifts and pack saturation; stage 3 is the output
// reset clears all stage valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module simd_packed_integer_alu (
  input  wire logic   clk,
  input  wire logic   rst_n,
  spia_in_if.sink     in_ch,
  spia_out_if.source  out_ch
);

  localparam int unsigned W = spia_pkg::DataW;

  // one enable for the whole pipe: move when the output slot is free or being taken
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 1: operand capture and first-level work
  logic         v1_r;
  logic [3:0]   op1_r;
  logic [1:0]   es1_r;
  logic [W-1:0] a1_r, b1_r;
  logic         ok1_r;
  // shift count decode: out of range flag, logical and clamped arithmetic counts
  logic         big1_r;
  logic [6:0]   shl1_r;
  logic [6:0]   sha1_r;
  // 16-bit products, one per lane
  logic [31:0]  sp1_r [spia_pkg::MulLanes];
  logic [31:0]  up1_r [spia_pkg::MulLanes];

  logic [W-1:0] a_in, b_in;
  assign a_in = {in_ch.a_hi, in_ch.a_lo};
  assign b_in = {in_ch.b_hi, in_ch.b_lo};

  logic [6:0]   lw_in;     // lane width in bits
  logic         big_in;

  always_comb begin
    lw_in  = 7'd8 << in_ch.lane_code;
    // the count is all 64 bits of b_lo
    big_in = (in_ch.b_lo >= {57'd0, lw_in});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r  <= in_ch.opcode;
      es1_r  <= in_ch.lane_code;
      a1_r   <= a_in;
      b1_r   <= b_in;
      ok1_r  <= spia_pkg::combo_ok(in_ch.opcode, in_ch.lane_code);
      big1_r <= big_in;
      shl1_r <= in_ch.b_lo[6:0];
      sha1_r <= big_in ? (lw_in - 7'd1) : in_ch.b_lo[6:0];
      for (int i = 0; i < spia_pkg::MulLanes; i++) begin
        sp1_r[i] <= $signed({{16{a_in[16*i+15]}}, a_in[16*i +: 16]}) *
                    $signed({{16{b_in[16*i+15]}}, b_in[16*i +: 16]});
        up1_r[i] <= {16'd0, a_in[16*i +: 16]} * {16'd0, b_in[16*i +: 16]};
      end
    end
  end

  // ---------------- stage 2: lane operations
  // lane compares per width, computed independently per lane
  logic [W-1:0] res2;

  function automatic logic [63:0] lane_op(input logic [3:0] op, input logic [63:0] x,
                                          input logic [63:0] y, input int w);
    logic [63:0] z, m, sb;
    logic        slt_xy, slt_yx;
    logic [64:0] s;
    m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    sb = 64'd1 << (w - 1);
    x = x & m;
    y = y & m;
    slt_xy = (x ^ sb) < (y ^ sb);
    slt_yx = (y ^ sb) < (x ^ sb);
    s = {1'b0, x} + {1'b0, y} + 65'd1;
    z = '0;
    case (op)
      spia_pkg::OP_CMPEQ: z = (x == y) ? m : '0;
      spia_pkg::OP_CMPGT: z = slt_yx ? m : '0;
      spia_pkg::OP_SMIN:  z = slt_xy ? x : y;
      spia_pkg::OP_SMAX:  z = slt_yx ? x : y;
      spia_pkg::OP_UMIN:  z = (x < y) ? x : y;
      spia_pkg::OP_UMAX:  z = (x > y) ? x : y;
      spia_pkg::OP_AVG:   z = s[64:1];
      default:            z = '0;
    endcase
    return z & m;
  endfunction

  function automatic logic [63:0] lane_shift(input logic [3:0] op, input logic [63:0] x,
                                             input int w, input logic big,
                                             input logic [6:0] cl, input logic [6:0] ca);
    logic [63:0] z, m, sx;
    m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    x = x & m;
    sx = x[w-1] ? ~m : '0;
    z = '0;
    case (op)
      spia_pkg::OP_SLL: z = big ? '0 : (x << cl);
      spia_pkg::OP_SRL: z = big ? '0 : (x >> cl);
      spia_pkg::OP_SRA: z = 64'((sx | x) >> ca);
      default:          z = '0;
    endcase
    return z & m;
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] s, input logic uns);
    logic [15:0] r;
    if (uns) begin
      r = s[31] ? 16'd0 : ((s[31:16] != 16'd0) ? 16'hffff : s[15:0]);
    end else begin
      r = ($signed(s) < -32768) ? 16'h8000 :
          (($signed(s) > 32767) ? 16'h7fff : s[15:0]);
    end
    return r;
  endfunction

  function automatic logic [7:0] sat8(input logic [15:0] s, input logic uns);
    logic [7:0] r;
    if (uns) begin
      r = s[15] ? 8'd0 : ((s[15:8] != 8'd0) ? 8'hff : s[7:0]);
    end else begin
      r = ($signed(s) < -128) ? 8'h80 : (($signed(s) > 127) ? 8'h7f : s[7:0]);
    end
    return r;
  endfunction

  logic [W-1:0] r8, r16, r32, r64, rmul, rpk;
  logic         uns;

  always_comb begin
    uns = (op1_r == spia_pkg::OP_PACKUS);
    for (int i = 0; i < 16; i++) begin
      r8[8*i +: 8] = 8'(lane_op(op1_r, {56'd0, a1_r[8*i +: 8]}, {56'd0, b1_r[8*i +: 8]}, 8));
    end
    for (int i = 0; i < 8; i++) begin
      r16[16*i +: 16] =
        (op1_r == spia_pkg::OP_SLL || op1_r == spia_pkg::OP_SRL ||
         op1_r == spia_pkg::OP_SRA)
        ? 16'(lane_shift(op1_r, {48'd0, a1_r[16*i +: 16]}, 16, big1_r, shl1_r, sha1_r))
        : 16'(lane_op(op1_r, {48'd0, a1_r[16*i +: 16]}, {48'd0, b1_r[16*i +: 16]}, 16));
      rmul[16*i +: 16] = (op1_r == spia_pkg::OP_SMULHI) ? sp1_r[i][31:16]
                                                        : up1_r[i][31:16];
    end
    for (int i = 0; i < 4; i++) begin
      r32[32*i +: 32] =
        (op1_r == spia_pkg::OP_SLL || op1_r == spia_pkg::OP_SRL ||
         op1_r == spia_pkg::OP_SRA)
        ? 32'(lane_shift(op1_r, {32'd0, a1_r[32*i +: 32]}, 32, big1_r, shl1_r, sha1_r))
        : 32'(lane_op(op1_r, {32'd0, a1_r[32*i +: 32]}, {32'd0, b1_r[32*i +: 32]}, 32));
    end
    for (int i = 0; i < 2; i++) begin
      r64[64*i +: 64] =
        (op1_r == spia_pkg::OP_SLL || op1_r == spia_pkg::OP_SRL)
        ? lane_shift(op1_r, a1_r[64*i +: 64], 64, big1_r, shl1_r, sha1_r)
        : lane_op(op1_r, a1_r[64*i +: 64], b1_r[64*i +: 64], 64);
    end
    rpk = '0;
    if (es1_r == spia_pkg::ES_16) begin
      for (int i = 0; i < 8; i++) begin
        rpk[8*i +: 8]      = sat8(a1_r[16*i +: 16], uns);
        rpk[64 + 8*i +: 8] = sat8(b1_r[16*i +: 16], uns);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        rpk[16*i +: 16]      = sat16(a1_r[32*i +: 32], uns);
        rpk[64 + 16*i +: 16] = sat16(b1_r[32*i +: 32], uns);
      end
    end

    if (!ok1_r) begin
      res2 = '0;
    end else if (op1_r == spia_pkg::OP_PACKSS || op1_r == spia_pkg::OP_PACKUS) begin
      res2 = rpk;
    end else if (op1_r == spia_pkg::OP_SMULHI || op1_r == spia_pkg::OP_UMULHI) begin
      res2 = rmul;
    end else begin
      case (es1_r)
        spia_pkg::ES_8:  res2 = r8;
        spia_pkg::ES_16: res2 = r16;
        spia_pkg::ES_32: res2 = r32;
        default:         res2 = r64;
      endcase
    end
  end

  logic         v2_r;
  logic [W-1:0] res2_r;
  logic         bad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res2_r <= res2;
      bad2_r <= !ok1_r;
    end
  end

  // ---------------- stage 3: output register
  logic         v3_r;
  logic [W-1:0] res3_r;
  logic         bad3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res3_r <= res2_r;
      bad3_r <= bad2_r;
    end
  end

  assign out_ch.valid     = v3_r;
  assign out_ch.r_lo      = res3_r[63:0];
  assign out_ch.r_hi      = res3_r[127:64];
  assign out_ch.bad_combo = bad3_r;

  // an unsupported pair always yields a zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && bad3_r |-> res3_r == '0)
    else $error("bad combo with nonzero result");

  // a stalled pipe keeps its stage valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v2_r) && $stable(v1_r))
    else $error("stage valid moved under stall");

  // an accepted transaction reaches stage one on the same advance
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && adv |=> v1_r)
    else $error("accepted transaction lost");

endmodule
`default_nettype wire

// ===== tb/spia_tb_if.sv =====
// testbench-side note: the channel interfaces come from src/spia_if.sv
// this file holds the small transaction records shared by the testbench top
// depends on nothing
`timescale 1ns / 1ps
package spia_tb_pkg;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  lane_code;
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] b_lo;
    logic [63:0] b_hi;
  } alu_op_t;

  typedef struct packed {
    logic [63:0] r_lo;
    logic [63:0] r_hi;
    logic        bad_combo;
  } alu_res_t;
endpackage

// ===== tb/testbench.sv =====
// testbench for simd_packed_integer_alu: directed and random transactions, a lane-wise
// predictor and an in-order scoreboard; depends on spia_pkg, spia_tb_pkg and spia_if.sv
`timescale 1ns / 1ps
module testbench;

  localparam int HoldLen = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  spia_in_if  in_ch ();
  spia_out_if out_ch ();

  simd_packed_integer_alu dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  spia_tb_pkg::alu_op_t  pending_ops[$];
  spia_tb_pkg::alu_res_t expected_res[$];
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_req = 1'b0;
  int       hold_cnt = 0;
  logic     hold_off;
  int       errors = 0;
  int       quiet_cycles = 0;

  // lane-wise model of the alu, lane 0 in the low bits
  function automatic spia_tb_pkg::alu_res_t alu_predict(spia_tb_pkg::alu_op_t op);
    logic [127:0] a, b, r;
    logic [63:0]  x, y, z, m, cnt;
    int           w, n, d, c;
    longint       s, lo, hi;
    logic         ok;
    spia_tb_pkg::alu_res_t res;
    a = {op.a_hi, op.a_lo};
    b = {op.b_hi, op.b_lo};
    r = '0;
    cnt = op.b_lo;
    w = 8 << op.lane_code;
    n = 128 / w;
    m = (w == 64) ? '1 : ((64'd1 << w) - 1);
    case (op.opcode)
      spia_pkg::OP_CMPEQ, spia_pkg::OP_CMPGT: ok = 1'b1;
      spia_pkg::OP_SMIN, spia_pkg::OP_SMAX, spia_pkg::OP_UMIN, spia_pkg::OP_UMAX:
        ok = (w <= 32);
      spia_pkg::OP_AVG: ok = (w <= 16);
      spia_pkg::OP_SMULHI, spia_pkg::OP_UMULHI: ok = (w == 16);
      spia_pkg::OP_SLL, spia_pkg::OP_SRL: ok = (w >= 16);
      spia_pkg::OP_SRA, spia_pkg::OP_PACKSS, spia_pkg::OP_PACKUS: ok = (w == 16 || w == 32);
      default: ok = 1'b0;
    endcase
    res.bad_combo = !ok;
    if (ok && (op.opcode == spia_pkg::OP_PACKSS || op.opcode == spia_pkg::OP_PACKUS)) begin
      d = w / 2;
      lo = (op.opcode == spia_pkg::OP_PACKSS) ? -(64'sd1 <<< (d - 1)) : 0;
      hi = (op.opcode == spia_pkg::OP_PACKSS) ? (64'sd1 <<< (d - 1)) - 1
                                               : (64'sd1 <<< d) - 1;
      for (int i = 0; i < 2 * n; i++) begin
        x = ((i < n) ? (a >> ((i % n) * w)) : (b >> ((i % n) * w))) & m;
        s = x[w-1] ? longint'(x) - (64'sd1 <<< w) : longint'(x);
        if (s < lo) s = lo;
        if (s > hi) s = hi;
        r |= (128'(s) & ((128'd1 << d) - 1)) << (i * d);
      end
    end else if (ok) begin
      for (int i = 0; i < n; i++) begin
        x = (a >> (i * w)) & m;
        y = (b >> (i * w)) & m;
        // flipping the sign bit turns signed order into unsigned order
        case (op.opcode)
          spia_pkg::OP_CMPEQ: z = (x == y) ? m : 0;
          spia_pkg::OP_CMPGT:
            z = ((x ^ (64'd1 << (w-1))) > (y ^ (64'd1 << (w-1)))) ? m : 0;
          spia_pkg::OP_SMIN:
            z = ((x ^ (64'd1 << (w-1))) < (y ^ (64'd1 << (w-1)))) ? x : y;
          spia_pkg::OP_SMAX:
            z = ((x ^ (64'd1 << (w-1))) > (y ^ (64'd1 << (w-1)))) ? x : y;
          spia_pkg::OP_UMIN: z = (x < y) ? x : y;
          spia_pkg::OP_UMAX: z = (x > y) ? x : y;
          spia_pkg::OP_AVG: z = (x + y + 1) >> 1;
          spia_pkg::OP_SMULHI: begin
            s = $signed({{48{x[15]}}, x[15:0]}) * $signed({{48{y[15]}}, y[15:0]});
            z = 64'(s >>> 16) & 64'hffff;
          end
          spia_pkg::OP_UMULHI: z = ((x * y) >> 16) & 64'hffff;
          spia_pkg::OP_SLL: z = (cnt < w) ? (x << cnt) : 0;
          spia_pkg::OP_SRL: z = (cnt < w) ? (x >> cnt) : 0;
          spia_pkg::OP_SRA: begin
            c = (cnt > w - 1) ? w - 1 : int'(cnt);
            z = x >> c;
            if (x[w-1]) z |= m & ~(m >> c);
          end
          default: z = 0;
        endcase
        r |= 128'(z & m) << (i * w);
      end
    end
    res.r_lo = r[63:0];
    res.r_hi = r[127:64];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // operand values biased toward lane extremes
  function automatic logic [63:0] edgy64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h8080_8080_8080_8080 ^ (rand64() & {8{8'h01}});
      3: return 64'h7fff_8000_7f80_ff01;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] shift_count();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 70));
      1: return rand64();
      2: return {32'h1, 32'($urandom_range(0, 15))};
      default: return 64'($urandom_range(0, 33));
    endcase
  endfunction

  task automatic push_op(input logic [3:0] opc, input logic [1:0] es,
                         input logic [63:0] al, ah, bl, bh);
    spia_tb_pkg::alu_op_t op;
    op = '{opc, es, al, ah, bl, bh};
    pending_ops = {pending_ops, op};
  endtask

  // driver: one nonblocking update of valid per edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res = {expected_res,
                        alu_predict({in_ch.opcode, in_ch.lane_code, in_ch.a_lo,
                                     in_ch.a_hi, in_ch.b_lo, in_ch.b_hi})};
        void'(pending_ops.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          spia_tb_pkg::alu_op_t nx;
          nx = pending_ops[0];
          in_ch.valid <= 1'b1;
          {in_ch.opcode, in_ch.lane_code, in_ch.a_lo, in_ch.a_hi, in_ch.b_lo, in_ch.b_hi}
            <= nx;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here once requested
  assign hold_off = hold_req && (hold_cnt < HoldLen);

  always @(posedge clk) begin
    if (!hold_req) hold_cnt <= 0;
    else if (hold_cnt < HoldLen) hold_cnt <= hold_cnt + 1;
  end

  // receiver ready and result checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result transaction r_lo=%h r_hi=%h", out_ch.r_lo, out_ch.r_hi);
          errors++;
        end else begin
          spia_tb_pkg::alu_res_t e;
          e = expected_res.pop_front();
          if (out_ch.r_lo !== e.r_lo) begin
            $error("r_lo expected %h actual %h", e.r_lo, out_ch.r_lo);
            errors++;
          end
          if (out_ch.r_hi !== e.r_hi) begin
            $error("r_hi expected %h actual %h", e.r_hi, out_ch.r_hi);
            errors++;
          end
          if (out_ch.bad_combo !== e.bad_combo) begin
            $error("bad_combo expected %b actual %b", e.bad_combo, out_ch.bad_combo);
            errors++;
          end
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ops.size() != 0 || expected_res.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    logic [3:0] opc;
    for (int k = 0; k < count; k++) begin
      opc = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                         : 4'($urandom_range(0, 13));
      if (opc == spia_pkg::OP_SLL || opc == spia_pkg::OP_SRL || opc == spia_pkg::OP_SRA)
        push_op(opc, 2'($urandom()), edgy64(), edgy64(), shift_count(), rand64());
      else
        push_op(opc, 2'($urandom()), edgy64(), edgy64(), edgy64(), edgy64());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.lane_code = '0;
    in_ch.a_lo = '0;
    in_ch.a_hi = '0;
    in_ch.b_lo = '0;
    in_ch.b_hi = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every opcode value 0 to 15, each at the width o % 4, plus shift and saturation corners
    for (int o = 0; o < 16; o++)
      push_op(4'(o), 2'(o % 4), '1, 64'h8000_0000_0000_0000, 64'h7f7f_7f7f_0001_8000, '0);
    push_op(spia_pkg::OP_SLL, spia_pkg::ES_64, '1, '1, 64'd63, '0);
    push_op(spia_pkg::OP_SRL, spia_pkg::ES_16, '1, '1, 64'd16, '0);
    push_op(spia_pkg::OP_SRA, spia_pkg::ES_32, 64'h8000_0000_7fff_ffff, '1,
            64'h1_0000_0000, '0);
    push_op(spia_pkg::OP_PACKSS, spia_pkg::ES_32, 64'h8000_0000_7fff_ffff,
            64'h0000_8000_ffff_7fff, '1, '0);
    push_op(spia_pkg::OP_PACKUS, spia_pkg::ES_16, 64'h8000_7fff_00ff_0100, '1,
            64'h0080_ff80, '0);
    push_op(spia_pkg::OP_AVG, spia_pkg::ES_8, '1, '1, '1, '0);
    push_op(spia_pkg::OP_SMULHI, spia_pkg::ES_16, 64'h8000_8000_7fff_ffff, '0,
            64'h8000_7fff_7fff_ffff, '0);
    push_op(spia_pkg::OP_UMULHI, spia_pkg::ES_16, '1, '1, '1, '1);
    drain();

    random_phase(250);
    drain();
    idle_pct = 52;
    random_phase(250);
    drain();
    idle_pct = 0;
    stall_pct = 52;
    random_phase(250);
    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    wait (hold_cnt == HoldLen);
    hold_req = 1'b0;
    drain();
    idle_pct = 35;
    stall_pct = 35;
    random_phase(300);
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
